// File: sv/lprp_pkg.sv
// ----------------------------------------------------------------------------
// lprp_pkg: shared types and constants of the record parser
// Phase codes, error codes, byte kinds, per-step state and result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lprp_pkg;

  // frame geometry
  localparam int unsigned   BYTE_W          = 8;
  localparam int unsigned   LEFT_W          = 26;
  localparam int unsigned   LEN_W           = 64;
  localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 64'd67108864;
  localparam logic [LEN_W-1:0] FRAME_LIMIT     = MAX_FRAME_BYTES - 64'd1;

  // varint decoding
  localparam logic [3:0]    VARINT_MAX_BYTES = 4'd10;
  localparam logic [6:0]    VARINT_BITS      = 7'd7;

  // stream widths
  localparam int unsigned   IN_TDATA_W   = 40;
  localparam int unsigned   OUT_TDATA_W  = 72;
  localparam int unsigned   OUT_TUSER_W  = 7;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_KEYLEN = 4'b0001,
    PH_KEY    = 4'b0010,
    PH_VALLEN = 4'b0100,
    PH_VAL    = 4'b1000
  } phase_t;

  // byte classification codes
  localparam logic [1:0] KIND_KEYLEN = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_VALLEN = 2'd2;
  localparam logic [1:0] KIND_VAL    = 2'd3;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_OVERLONG   = 3'd1,
    ERR_PAST_FRAME = 3'd2,
    ERR_MID_RECORD = 3'd3,
    ERR_HALTED     = 3'd4
  } err_t;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t            phase;
    logic [LEN_W-1:0]  accum;
    logic [3:0]        vcount;
    logic [LEFT_W-1:0] fbl;
    logic              halted;
  } state_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [1:0]        byte_kind;
    logic              length_done;
    logic [LEN_W-1:0]  length_value;
    logic              field_end;
    logic              record_end;
    err_t              error_code;
  } result_t;

  // byte kind reported for a phase
  function automatic logic [1:0] kind_of(input phase_t p);
    logic [1:0] k;
    case (p)
      PH_KEYLEN: k = KIND_KEYLEN;
      PH_KEY:    k = KIND_KEY;
      PH_VALLEN: k = KIND_VALLEN;
      PH_VAL:    k = KIND_VAL;
      default:   k = KIND_KEYLEN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: sv/lprp_in_stage.sv
// ----------------------------------------------------------------------------
// lprp_in_stage: input register of the record parser
// Captures one byte transfer and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lprp_in_stage
  import lprp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // data_byte, bytes_left
  input  wire logic                  advance,
  output logic                       vld,
  output logic [BYTE_W-1:0]          data_byte,
  output logic [LEFT_W-1:0]          bytes_left
);

  logic                 vld_r, vld_nxt;
  logic [BYTE_W-1:0]    byte_r;
  logic [LEFT_W-1:0]    left_r;
  logic                 take;

  // room when empty or when the held byte moves on this cycle
  assign in_tready = !vld_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata[BYTE_W-1:0];
      left_r <= in_tdata[BYTE_W+LEFT_W-1:BYTE_W];
    end
  end

  assign vld        = vld_r;
  assign data_byte  = byte_r;
  assign bytes_left = left_r;

endmodule

`default_nettype wire

// File: sv/lprp_core.sv
// ----------------------------------------------------------------------------
// lprp_core: per-byte parse step
// Classifies one byte, decodes LEB128 lengths, tracks field bytes and flags
// errors, giving the next parser state and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module lprp_core
  import lprp_pkg::*;
(
  input  wire state_t               st,
  input  wire logic [BYTE_W-1:0]    data_byte,
  input  wire logic [LEFT_W-1:0]    bytes_left,
  output state_t                    st_nxt,
  output result_t                   res
);

  logic [6:0]        shamt;
  logic [LEN_W-1:0]  contrib;
  logic [LEN_W-1:0]  acc_new;
  logic [LEN_W-1:0]  left_ext;
  logic [LEN_W-1:0]  limit;
  logic              past_frame;
  logic              len_zero;
  logic              last_byte;
  logic              is_len;
  logic [LEFT_W-1:0] fbl_dec;

  // varint contribution of this byte at bit 7*n, upper bits dropped
  assign shamt    = 7'(st.vcount) * VARINT_BITS;
  assign contrib  = {57'd0, data_byte[6:0]} << shamt;
  assign acc_new  = st.accum | contrib;

  // frame limit and length checks
  assign left_ext   = {{(LEN_W-LEFT_W){1'b0}}, bytes_left};
  assign limit      = (left_ext < FRAME_LIMIT) ? left_ext : FRAME_LIMIT;
  assign past_frame = acc_new > limit;
  assign len_zero   = (acc_new == '0);
  assign last_byte  = (bytes_left == '0);

  assign is_len  = (st.phase == PH_KEYLEN) || (st.phase == PH_VALLEN);
  assign fbl_dec = (st.fbl != '0) ? st.fbl - LEFT_W'(1) : '0;

  // step decision
  always_comb begin
    st_nxt           = st;
    res.byte_out     = data_byte;
    res.byte_kind    = kind_of(st.phase);
    res.length_done  = 1'b0;
    res.length_value = '0;
    res.field_end    = 1'b0;
    res.record_end   = 1'b0;
    res.error_code   = ERR_NONE;

    if (st.halted) begin
      res.byte_kind  = KIND_KEYLEN;
      res.error_code = ERR_HALTED;
    end else if (is_len) begin
      if (st.vcount >= VARINT_MAX_BYTES) begin
        st_nxt.halted  = 1'b1;
        res.error_code = ERR_OVERLONG;
      end else if (data_byte[7]) begin
        // continuation byte
        st_nxt.accum = acc_new;
        if (last_byte) begin
          st_nxt.halted  = 1'b1;
          res.error_code = ERR_MID_RECORD;
        end else begin
          st_nxt.vcount = st.vcount + 4'd1;
        end
      end else begin
        // final varint byte
        st_nxt.accum  = '0;
        st_nxt.vcount = '0;
        if (past_frame) begin
          st_nxt.halted  = 1'b1;
          res.error_code = ERR_PAST_FRAME;
        end else if (len_zero) begin
          if (st.phase == PH_KEYLEN) begin
            if (last_byte) begin
              st_nxt.halted  = 1'b1;
              res.error_code = ERR_MID_RECORD;
            end else begin
              st_nxt.phase    = PH_VALLEN;
              res.length_done = 1'b1;
              res.field_end   = 1'b1;
            end
          end else begin
            st_nxt.phase    = PH_KEYLEN;
            res.length_done = 1'b1;
            res.field_end   = 1'b1;
            res.record_end  = 1'b1;
          end
        end else begin
          st_nxt.fbl       = acc_new[LEFT_W-1:0];
          st_nxt.phase     = (st.phase == PH_KEYLEN) ? PH_KEY : PH_VAL;
          res.length_done  = 1'b1;
          res.length_value = acc_new;
        end
      end
    end else begin
      // key or value payload byte
      st_nxt.fbl = fbl_dec;
      if (fbl_dec == '0) begin
        if (st.phase == PH_KEY) begin
          if (last_byte) begin
            st_nxt.halted  = 1'b1;
            res.error_code = ERR_MID_RECORD;
          end else begin
            st_nxt.phase  = PH_VALLEN;
            res.field_end = 1'b1;
          end
        end else begin
          st_nxt.phase   = PH_KEYLEN;
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
        end
      end else if (last_byte) begin
        st_nxt.halted  = 1'b1;
        res.error_code = ERR_MID_RECORD;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/length_prefixed_record_parser_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_record_parser_unit: LEB128 length-prefixed record parser
// Byte stream in, one classified result per byte out.
// ----------------------------------------------------------------------------
// The unit takes one frame byte per transfer and returns exactly one result
// per byte, in order. It sustains one byte per clock cycle while the output
// side is ready; a result passes the input register and then the result
// register before it leaves. The rate rests on the parse state update
// (varint accumulator, field byte counter and phase), done combinationally
// between the input register and the result register. in_tready follows
// out_tready combinationally when both registers are full. After any error
// the unit stays halted, answering every byte with error code 4, until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_record_parser_unit
  import lprp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], bytes_left[33:8]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // byte_out[7:0], length_value[71:8]
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // byte_kind[1:0], length_done[2],
                                                  // field_end[3], error_code[6:4]
  output logic                        out_tlast   // record_end
);

  logic              in_vld;
  logic [BYTE_W-1:0] data_byte;
  logic [LEFT_W-1:0] bytes_left;
  logic              advance;
  logic              out_vld_r, out_vld_nxt;
  state_t            state_r, state_nxt;
  result_t           res;
  result_t           res_r;

  // a held byte moves when the result register is free or draining
  assign advance = in_vld && (!out_vld_r || out_tready);

  lprp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .vld        (in_vld),
    .data_byte  (data_byte),
    .bytes_left (bytes_left)
  );

  lprp_core u_core (
    .st         (state_r),
    .data_byte  (data_byte),
    .bytes_left (bytes_left),
    .st_nxt     (state_nxt),
    .res        (res)
  );

  // parser state, updated once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase  <= PH_KEYLEN;
      state_r.accum  <= '0;
      state_r.vcount <= '0;
      state_r.fbl    <= '0;
      state_r.halted <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.length_value, res_r.byte_out};
  assign out_tuser  = {res_r.error_code, res_r.field_end, res_r.length_done,
                       res_r.byte_kind};
  assign out_tlast  = res_r.record_end;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("parser left the halted state");

  // a stalled result freezes the parser state
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> $stable(state_r))
    else $error("parser state moved while the result was stalled");

  // varint byte count never passes the limit
  a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.vcount <= VARINT_MAX_BYTES)
    else $error("varint byte count out of range");

  // halted results carry no length and no record mark
  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.error_code == ERR_HALTED) |->
      (res_r.length_value == '0 && !res_r.record_end && !res_r.length_done))
    else $error("halted result carries flags");

  // a length is only reported on a clean transfer
  a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.length_done) |-> (res_r.error_code == ERR_NONE))
    else $error("length reported together with an error");

endmodule

`default_nettype wire

// File: dv/length_prefixed_record_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_record_parser_unit_tb: self-checking bench of the parser
// Streams framed records of LEB128 key and value lengths through the unit,
// predicts every classified byte in step with the input side and compares
// each result transfer field by field. Ends with one error and a halted tail.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_record_parser_unit_tb;
  import lprp_pkg::*;

  localparam int unsigned LEFT_MAX     = (32'd1 << LEFT_W) - 1;
  localparam int          PHASE_BYTES  = 362;
  localparam int          MAX_REPORTS  = 100;
  localparam int          DRAIN_CYCLES = 10;

  // one frame byte as offered on the input side
  typedef struct packed {
    logic [LEFT_W-1:0] left;
    logic [BYTE_W-1:0] data;
  } frame_byte_t;

  // closing error scenarios
  typedef enum int {
    TAIL_OVERLONG,
    TAIL_PAST_FRAME,
    TAIL_HUGE_LEN,
    TAIL_CONT_AT_END,
    TAIL_EMPTY_KEY_AT_END,
    TAIL_KEY_AT_END,
    TAIL_OWED_AT_END
  } tail_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  bit          in_taken      = 1'b0;
  int          mismatches    = 0;
  int          results_seen  = 0;
  int          bytes_queued  = 0;
  int          bytes_taken   = 0;

  frame_byte_t pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  frame_buf[$];

  // mirror of the parse state
  logic [1:0]        mir_kind   = KIND_KEYLEN;
  logic [LEN_W-1:0]  mir_accum  = '0;
  logic [3:0]        mir_vcount = '0;
  logic [LEFT_W-1:0] mir_fbl    = '0;
  bit                mir_halted = 1'b0;

  length_prefixed_record_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // expected classification of one byte, advancing the mirrored state
  function automatic result_t classify_byte(input logic [7:0] b,
                                            input logic [LEFT_W-1:0] left);
    result_t          r;
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] len;
    r = '0;
    r.byte_out   = b;
    r.byte_kind  = mir_kind;
    r.error_code = ERR_NONE;
    lim = LEN_W'(left);
    if (lim > FRAME_LIMIT) lim = FRAME_LIMIT;
    if (mir_halted) begin
      r.byte_kind  = KIND_KEYLEN;
      r.error_code = ERR_HALTED;
    end else if (mir_kind == KIND_KEYLEN || mir_kind == KIND_VALLEN) begin
      if (mir_vcount >= VARINT_MAX_BYTES) begin
        mir_halted   = 1'b1;
        r.error_code = ERR_OVERLONG;
      end else begin
        // bits above bit 63 fall off the accumulator
        mir_accum = mir_accum | ({57'd0, b[6:0]} << (7 * mir_vcount));
        if (b[7]) begin
          if (left == 0) begin
            mir_halted   = 1'b1;
            r.error_code = ERR_MID_RECORD;
          end else begin
            mir_vcount = mir_vcount + 4'd1;
          end
        end else begin
          len        = mir_accum;
          mir_accum  = '0;
          mir_vcount = '0;
          if (len > lim) begin
            mir_halted   = 1'b1;
            r.error_code = ERR_PAST_FRAME;
          end else if (len == 0) begin
            // empty field, ends on the length byte itself
            if (mir_kind == KIND_KEYLEN && left == 0) begin
              mir_halted   = 1'b1;
              r.error_code = ERR_MID_RECORD;
            end else begin
              r.length_done = 1'b1;
              r.field_end   = 1'b1;
              r.record_end  = (mir_kind == KIND_VALLEN);
              mir_kind = (mir_kind == KIND_KEYLEN) ? KIND_VALLEN : KIND_KEYLEN;
            end
          end else begin
            mir_fbl        = len[LEFT_W-1:0];
            r.length_done  = 1'b1;
            r.length_value = len;
            mir_kind = (mir_kind == KIND_KEYLEN) ? KIND_KEY : KIND_VAL;
          end
        end
      end
    end else begin
      // key or value data byte
      if (mir_fbl != 0) mir_fbl = mir_fbl - LEFT_W'(1);
      if (mir_fbl == 0) begin
        if (mir_kind == KIND_KEY && left == 0) begin
          mir_halted   = 1'b1;
          r.error_code = ERR_MID_RECORD;
        end else begin
          r.field_end  = 1'b1;
          r.record_end = (mir_kind == KIND_VAL);
          mir_kind = (mir_kind == KIND_KEY) ? KIND_VALLEN : KIND_KEYLEN;
        end
      end else if (left == 0) begin
        mir_halted   = 1'b1;
        r.error_code = ERR_MID_RECORD;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 64'(out_tdata[7:0]), 64'd0);
    end else begin
      want = expected_results.pop_front();
      if (out_tdata[7:0] !== want.byte_out)
        report_mismatch("byte_out", 64'(out_tdata[7:0]), 64'(want.byte_out));
      if (out_tuser[1:0] !== want.byte_kind)
        report_mismatch("byte_kind", 64'(out_tuser[1:0]), 64'(want.byte_kind));
      if (out_tuser[2] !== want.length_done)
        report_mismatch("length_done", 64'(out_tuser[2]), 64'(want.length_done));
      if (out_tdata[71:8] !== want.length_value)
        report_mismatch("length_value", out_tdata[71:8], want.length_value);
      if (out_tuser[3] !== want.field_end)
        report_mismatch("field_end", 64'(out_tuser[3]), 64'(want.field_end));
      if (out_tlast !== want.record_end)
        report_mismatch("record_end", 64'(out_tlast), 64'(want.record_end));
      if (out_tuser[6:4] !== want.error_code)
        report_mismatch("error_code", 64'(out_tuser[6:4]), 64'(want.error_code));
    end
    results_seen++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(),
                                classify_byte(in_tdata[7:0], in_tdata[33:8]));
        void'(pending_bytes.pop_front());
        in_taken = 1'b1;
        bytes_taken++;
      end
      if (out_tvalid && out_tready) check_result();
    end
  end

  // drive both channels at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'({pending_bytes[0].left, pending_bytes[0].data});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic [LEFT_W-1:0] left);
    frame_byte_t fb;
    fb.data = b;
    fb.left = left;
    pending_bytes.insert(pending_bytes.size(), fb);
    bytes_queued++;
  endtask

  // leb128 encoding, sometimes padded with redundant groups up to ten bytes
  task automatic push_varint(input logic [63:0] len);
    logic [63:0] v;
    int          n;
    int          total;
    logic [6:0]  grp;
    v = len;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    total = ($urandom_range(0, 7) == 0) ? $urandom_range(n, 10) : n;
    for (int i = 0; i < total; i++) begin
      grp = v[6:0];
      // tenth group keeps only its low bit, so the rest may be junk
      if (i == 9 && i >= n) grp = {6'($urandom_range(0, 63)), 1'b0};
      frame_buf.insert(frame_buf.size(), {(i < total - 1), grp});
      v = v >> 7;
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 99) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  task automatic build_field();
    int len;
    len = pick_len();
    push_varint(64'(len));
    repeat (len) frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
  endtask

  // one frame of records; bytes_left counts down exactly or overstates
  task automatic emit_frame();
    int unsigned nrec;
    bit          exact;
    int unsigned rem;
    frame_buf.delete();
    nrec = $urandom_range(1, 4);
    repeat (nrec) begin
      build_field();
      build_field();
    end
    exact = $urandom_range(0, 1);
    foreach (frame_buf[i]) begin
      rem = frame_buf.size() - 1 - i;
      if (exact) push_byte(frame_buf[i], LEFT_W'(rem));
      else push_byte(frame_buf[i], LEFT_W'(rem + $urandom_range(0, LEFT_MAX - rem)));
    end
  endtask

  task automatic random_phase(input int send_pct, input int hold_pct);
    int target;
    send_idle_pct = send_pct;
    stall_pct     = hold_pct;
    target = bytes_queued + PHASE_BYTES;
    while (bytes_queued < target) emit_frame();
  endtask

  // hold off new input until every byte went in and every result came out
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic push_rand_left(input logic [7:0] b);
    push_byte(b, LEFT_W'($urandom_range(1, LEFT_MAX)));
  endtask

  // a single error closes the run, followed by bytes of the halted unit
  task automatic error_tail();
    tail_t sel;
    bit    in_val;
    int    len;
    sel    = tail_t'($urandom_range(0, 6));
    in_val = $urandom_range(0, 1);
    if (in_val) begin
      push_rand_left(8'h01);
      push_rand_left(8'($urandom_range(0, 255)));
    end
    case (sel)
      TAIL_OVERLONG: begin
        repeat (11) push_rand_left({1'b1, 7'($urandom_range(0, 127))});
      end
      TAIL_PAST_FRAME: begin
        len = $urandom_range(1, 127);
        push_byte(8'(len), LEFT_W'($urandom_range(0, len - 1)));
      end
      TAIL_HUGE_LEN: begin
        // all-ones length against the largest frame, no wrap allowed
        repeat (9) push_rand_left(8'hff);
        push_byte(8'h01, LEFT_W'(LEFT_MAX));
      end
      TAIL_CONT_AT_END: begin
        push_byte({1'b1, 7'($urandom_range(0, 127))}, '0);
      end
      TAIL_EMPTY_KEY_AT_END: begin
        if (in_val) push_byte(8'h00, '0);
        push_byte(8'h00, '0);
      end
      TAIL_KEY_AT_END: begin
        if (in_val) push_rand_left(8'h00);
        push_rand_left(8'h02);
        push_rand_left(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)), '0);
      end
      default: begin
        push_rand_left(8'h03);
        push_byte(8'($urandom_range(0, 255)), '0);
      end
    endcase
    repeat ($urandom_range(4, 8))
      push_byte(8'($urandom_range(0, 255)), LEFT_W'($urandom_range(0, LEFT_MAX)));
  endtask

  // stimulus sequence
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty key and empty value, the value ending the frame
    push_byte(8'h00, LEFT_W'(LEFT_MAX));
    push_byte(8'h00, '0);
    // ten-byte key length of one, junk above bit 63, all-ones bytes
    push_byte(8'h81, LEFT_W'(13));
    for (int i = 12; i >= 5; i--) push_byte(8'h80, LEFT_W'(i));
    push_byte(8'h7e, LEFT_W'(4));
    push_byte(8'hff, LEFT_W'(3));
    push_byte(8'h02, LEFT_W'(2));
    push_byte(8'h00, LEFT_W'(1));
    push_byte(8'hff, '0);
    // two-byte zero value length
    push_byte(8'h01, LEFT_W'(3));
    push_byte(8'h80, LEFT_W'(2));
    push_byte(8'h80, LEFT_W'(1));
    push_byte(8'h00, '0);
    // value length equal to the bytes left
    push_byte(8'h01, LEFT_W'(4));
    push_byte(8'h5a, LEFT_W'(3));
    push_byte(8'h02, LEFT_W'(2));
    push_byte(8'ha5, LEFT_W'(1));
    push_byte(8'h3c, '0);
    wait_drained();

    random_phase(0, 0);
    wait_drained();
    random_phase(48, 0);
    wait_drained();
    random_phase(0, 48);
    wait_drained();
    random_phase(24, 24);
    wait_drained();
    error_tail();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("length_prefixed_record_parser_unit test passed");
    else
      $display("length_prefixed_record_parser_unit test failed");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("length_prefixed_record_parser_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/lprp_pkg.sv
sv/lprp_in_stage.sv
sv/lprp_core.sv
sv/length_prefixed_record_parser_unit.sv
dv/length_prefixed_record_parser_unit_tb.sv
